FILE: hw/rtl/gapr_pkg.sv
// ----------------------------------------------------------------------------
// gapr_pkg
// Shared types and constants for the GNSS acknowledge packet receiver.
// ----------------------------------------------------------------------------
package gapr_pkg;

  // Field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned REG_DAT_W = 16;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned ELAPSED_W = 17;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ARM  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  // Outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_ACK     = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_REJECT  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_TIMEOUT = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_CLASS   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ID      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  // Register reset values
  localparam logic [BYTE_W-1:0]    RST_CLASS   = 8'h06;
  localparam logic [BYTE_W-1:0]    RST_ID      = 8'h00;
  localparam logic [REG_DAT_W-1:0] RST_TIMEOUT = 16'd1500;

  // Packet layout
  localparam logic [BYTE_W-1:0] HDR_SYNC1 = 8'hB5;
  localparam logic [BYTE_W-1:0] HDR_SYNC2 = 8'h62;
  localparam logic [BYTE_W-1:0] HDR_CLASS = 8'h05;
  localparam logic [BYTE_W-1:0] NAK_ID    = 8'h00;

  localparam logic [POS_W-1:0] POS_MSG_ID   = 4'd3;
  localparam logic [POS_W-1:0] POS_SUM_LO   = 4'd2;
  localparam logic [POS_W-1:0] POS_ACK_CLS  = 4'd6;
  localparam logic [POS_W-1:0] POS_ACK_ID   = 4'd7;
  localparam logic [POS_W-1:0] POS_CK_A     = 4'd8;
  localparam logic [POS_W-1:0] POS_CK_B     = 4'd9;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Live configuration seen by the parser
  typedef struct packed {
    logic [BYTE_W-1:0]    exp_class;
    logic [BYTE_W-1:0]    exp_id;
    logic [REG_DAT_W-1:0] timeout_ms;
  } gapr_cfg_t;

  // One step handed to the parser
  typedef struct packed {
    logic              go;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] rx_byte;
  } gapr_step_t;

  // Parser result
  typedef struct packed {
    logic                 vld;
    logic [OUTCOME_W-1:0] outcome;
  } gapr_res_t;

  // Header byte expected at positions 0 to 2
  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [1:0] idx);
    logic [BYTE_W-1:0] val;
    unique case (idx)
      2'd0:    val = HDR_SYNC1;
      2'd1:    val = HDR_SYNC2;
      default: val = HDR_CLASS;
    endcase
    return val;
  endfunction

endpackage

FILE: hw/rtl/gapr_if.sv
// ----------------------------------------------------------------------------
// gapr channel interfaces
// Valid/ready channels for commands, outcomes and register writes.
// ----------------------------------------------------------------------------

// Command channel
interface gapr_in_if;
  import gapr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

// Outcome channel
interface gapr_out_if;
  import gapr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;

  modport source (output valid, output outcome, input ready);
  modport sink   (input valid, input outcome, output ready);
endinterface

// Register write channel
interface gapr_cfg_if;
  import gapr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] reg_index;
  logic [REG_DAT_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: hw/rtl/gnss_ack_packet_receiver.sv
// ----------------------------------------------------------------------------
// gnss_ack_packet_receiver
// Waits for a 10-byte acknowledge packet after an arm command and reports
// acknowledged, rejected or timed out.
// ----------------------------------------------------------------------------
// One command (arm, received byte or millisecond tick) is taken per cycle.
// A command is captured in an input register at its transfer and processed
// from there once the output register is free or draining; any outcome is
// loaded into the output register at the end of that processing cycle.
// Commands follow back to back while the outcome channel keeps up;
// an outcome that is not taken holds the command waiting in the input
// register, which in turn stalls the command channel. Register writes are
// taken at any time and apply to every command processed after them, so they
// should be made while no command is waiting.
// ----------------------------------------------------------------------------
module gnss_ack_packet_receiver
  import gapr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  gapr_in_if.sink    in_ch,
  gapr_out_if.source out_ch,
  gapr_cfg_if.sink   cfg_ch
);

  // Configuration registers
  logic [BYTE_W-1:0]    exp_class_r;
  logic [BYTE_W-1:0]    exp_id_r;
  logic [REG_DAT_W-1:0] timeout_r;
  gapr_cfg_t            cfg;

  // Input register
  logic              in_vld_r, in_vld_nxt;
  logic [CMD_W-1:0]  in_cmd_r;
  logic [BYTE_W-1:0] in_byte_r;

  // Output register
  logic                 out_vld_r, out_vld_nxt;
  logic [OUTCOME_W-1:0] out_code_r;

  logic       proc_go;
  logic       in_rdy;
  gapr_step_t step;
  gapr_res_t  res;

  assign cfg_ch.ready = 1'b1;
  assign cfg.exp_class  = exp_class_r;
  assign cfg.exp_id     = exp_id_r;
  assign cfg.timeout_ms = timeout_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_class_r <= RST_CLASS;
      exp_id_r    <= RST_ID;
      timeout_r   <= RST_TIMEOUT;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_CLASS:   exp_class_r <= cfg_ch.wdata[BYTE_W-1:0];
        REG_ID:      exp_id_r    <= cfg_ch.wdata[BYTE_W-1:0];
        REG_TIMEOUT: timeout_r   <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // Handshake: process when the output register is free or draining
  assign proc_go      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_rdy       = !in_vld_r || proc_go;
  assign in_ch.ready  = in_rdy;
  assign in_vld_nxt   = in_rdy ? in_ch.valid : in_vld_r;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (proc_go) begin
      out_vld_nxt = res.vld;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      in_cmd_r  <= in_ch.command;
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // Parser core
  assign step.go      = proc_go;
  assign step.command = in_cmd_r;
  assign step.rx_byte = in_byte_r;

  gapr_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cfg   (cfg),
    .res   (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res.vld) begin
      out_code_r <= res.outcome;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.outcome = out_code_r;

endmodule

FILE: hw/rtl/gapr_parser.sv
// ----------------------------------------------------------------------------
// gapr_parser
// Packet tracking state and the single-step update for one command.
// ----------------------------------------------------------------------------
module gapr_parser
  import gapr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  gapr_step_t step,
  input  gapr_cfg_t  cfg,
  output gapr_res_t  res
);

  logic                 waiting_r, waiting_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [BYTE_W-1:0]    sum_a_r, sum_a_nxt;
  logic [BYTE_W-1:0]    sum_b_r, sum_b_nxt;
  logic                 match_r, match_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;

  logic [BYTE_W-1:0]    sum_a_add;
  logic [BYTE_W-1:0]    sum_b_add;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic                 hdr_ok;
  logic                 in_sum;
  logic                 match_upd;

  // Candidate values shared by the step logic
  assign sum_a_add   = sum_a_r + step.rx_byte;
  assign sum_b_add   = sum_b_r + sum_a_add;
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r
                                                  : elapsed_r + ELAPSED_W'(1);
  assign hdr_ok      = (pos_r >= POS_MSG_ID) || (step.rx_byte == hdr_byte(pos_r[1:0]));
  assign in_sum      = (pos_r >= POS_SUM_LO) && (pos_r <= POS_ACK_ID);

  // Field and checksum check for the current byte
  always_comb begin
    match_upd = match_r;
    if (pos_r == POS_ACK_CLS && step.rx_byte != cfg.exp_class) match_upd = 1'b0;
    if (pos_r == POS_ACK_ID  && step.rx_byte != cfg.exp_id)    match_upd = 1'b0;
    if (pos_r == POS_CK_A    && step.rx_byte != sum_a_r)       match_upd = 1'b0;
    if (pos_r == POS_CK_B    && step.rx_byte != sum_b_r)       match_upd = 1'b0;
  end

  // Step update
  always_comb begin
    waiting_nxt = waiting_r;
    pos_nxt     = pos_r;
    sum_a_nxt   = sum_a_r;
    sum_b_nxt   = sum_b_r;
    match_nxt   = match_r;
    elapsed_nxt = elapsed_r;
    res.vld     = 1'b0;
    res.outcome = OUT_ACK;
    if (step.go) begin
      unique case (step.command)
        CMD_ARM: begin
          waiting_nxt = 1'b1;
          pos_nxt     = '0;
          sum_a_nxt   = '0;
          sum_b_nxt   = '0;
          match_nxt   = 1'b1;
          elapsed_nxt = '0;
        end
        CMD_TICK: begin
          if (waiting_r) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc > {1'b0, cfg.timeout_ms}) begin
              waiting_nxt = 1'b0;
              pos_nxt     = '0;
              res.vld     = 1'b1;
              res.outcome = OUT_TIMEOUT;
            end
          end
        end
        CMD_BYTE: begin
          if (waiting_r && hdr_ok) begin
            if (pos_r == POS_MSG_ID && step.rx_byte == NAK_ID) begin
              // nak ends the wait
              waiting_nxt = 1'b0;
              pos_nxt     = '0;
              res.vld     = 1'b1;
              res.outcome = OUT_REJECT;
            end else begin
              if (in_sum) begin
                sum_a_nxt = sum_a_add;
                sum_b_nxt = sum_b_add;
              end
              match_nxt = match_upd;
              if (pos_r == POS_CK_B) begin
                waiting_nxt = 1'b0;
                pos_nxt     = '0;
                res.vld     = 1'b1;
                res.outcome = match_upd ? OUT_ACK : OUT_REJECT;
              end else begin
                pos_nxt = pos_r + POS_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      pos_r     <= '0;
      sum_a_r   <= '0;
      sum_b_r   <= '0;
      match_r   <= 1'b1;
      elapsed_r <= '0;
    end else begin
      waiting_r <= waiting_nxt;
      pos_r     <= pos_nxt;
      sum_a_r   <= sum_a_nxt;
      sum_b_r   <= sum_b_nxt;
      match_r   <= match_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

FILE: tb/gapr_outcome_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gapr_outcome_checker
// Watches the command, register and outcome channels of the acknowledge
// packet receiver. It tracks the packet parser and the registers itself,
// queues the outcome that each accepted command should end in, and compares
// every outcome transfer with the oldest queued one.
// ----------------------------------------------------------------------------
module gapr_outcome_checker
  import gapr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [OUTCOME_W-1:0] out_outcome,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_reg_index,
  input  logic [REG_DAT_W-1:0] cfg_wdata,
  output int                   err_count,
  output int                   pending
);

  // Register copies
  logic [BYTE_W-1:0]    want_class;
  logic [BYTE_W-1:0]    want_id;
  logic [REG_DAT_W-1:0] limit_ms;

  // Parser copy
  logic                 armed;
  logic [POS_W-1:0]     pkt_pos;
  logic [BYTE_W-1:0]    ck_a;
  logic [BYTE_W-1:0]    ck_b;
  logic                 all_match;
  logic [ELAPSED_W-1:0] ms_count;

  // Outcomes still to come, oldest first
  logic [OUTCOME_W-1:0] outcome_q[$];

  // One line per mismatch
  task automatic report_mismatch(input string what, input logic [OUTCOME_W-1:0] seen,
                                 input logic [OUTCOME_W-1:0] wanted);
    $display("%0t: %s: outcome %0d, expected %0d", $time, what, seen, wanted);
    err_count = err_count + 1;
  endtask

  // Advance the parser copy by one command, queueing any outcome
  task automatic predict_outcome(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0]    sync;
    logic                 finished;
    logic [OUTCOME_W-1:0] code;
    finished = 1'b0;
    code     = OUT_ACK;
    case (pkt_pos)
      4'd0:    sync = HDR_SYNC1;
      4'd1:    sync = HDR_SYNC2;
      default: sync = HDR_CLASS;
    endcase
    if (cmd == CMD_ARM) begin
      // arm always restarts the wait from scratch
      armed     = 1'b1;
      pkt_pos   = '0;
      ck_a      = '0;
      ck_b      = '0;
      all_match = 1'b1;
      ms_count  = '0;
    end else if (armed && cmd == CMD_TICK) begin
      if (ms_count != ELAPSED_MAX) ms_count = ms_count + ELAPSED_W'(1);
      if (ms_count > {1'b0, limit_ms}) begin
        finished = 1'b1;
        code     = OUT_TIMEOUT;
      end
    end else if (armed && cmd == CMD_BYTE) begin
      if (pkt_pos < POS_MSG_ID && b != sync) begin
        // off-sequence header byte: dropped, position kept
      end else if (pkt_pos == POS_MSG_ID && b == NAK_ID) begin
        finished = 1'b1;
        code     = OUT_REJECT;
      end else begin
        if (pkt_pos >= POS_SUM_LO && pkt_pos <= POS_ACK_ID) begin
          ck_a = ck_a + b;
          ck_b = ck_b + ck_a;
        end
        if ((pkt_pos == POS_ACK_CLS && b != want_class) ||
            (pkt_pos == POS_ACK_ID  && b != want_id)    ||
            (pkt_pos == POS_CK_A    && b != ck_a)       ||
            (pkt_pos == POS_CK_B    && b != ck_b)) begin
          all_match = 1'b0;
        end
        if (pkt_pos == POS_CK_B) begin
          finished = 1'b1;
          code     = all_match ? OUT_ACK : OUT_REJECT;
        end else begin
          pkt_pos = pkt_pos + POS_W'(1);
        end
      end
    end
    // idle bytes, idle ticks and the spare command fall through untouched
    if (finished) begin
      armed   = 1'b0;
      pkt_pos = '0;
      outcome_q.push_back(code);
    end
  endtask

  // Sample all three channels at each edge
  always @(posedge clk) begin : watch
    logic [OUTCOME_W-1:0] wanted;
    if (!rst_n) begin
      want_class = RST_CLASS;
      want_id    = RST_ID;
      limit_ms   = RST_TIMEOUT;
      armed      = 1'b0;
      pkt_pos    = '0;
      ck_a       = '0;
      ck_b       = '0;
      all_match  = 1'b1;
      ms_count   = '0;
      outcome_q.delete();
    end else begin
      // outcomes first: none can stem from a command taken at this edge
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("outcome with nothing pending", out_outcome, 2'bxx);
        end else begin
          wanted = outcome_q.pop_front();
          if (out_outcome !== wanted) report_mismatch("wrong outcome", out_outcome, wanted);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_index)
          REG_CLASS:   want_class = cfg_wdata[BYTE_W-1:0];
          REG_ID:      want_id    = cfg_wdata[BYTE_W-1:0];
          REG_TIMEOUT: limit_ms   = cfg_wdata;
          default:     ;
        endcase
      end
      if (in_valid && in_ready) predict_outcome(in_command, in_rx_byte);
    end
    pending <= outcome_q.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the GNSS acknowledge packet receiver. A directed
// run covers idle input, the spare command, header slips, nak, re-arm, a
// matched acknowledge and a zero timeout; then random phases of packets,
// flawed packets, timeouts and noise under changing register settings, with
// random gaps on both channels and one long outcome hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import gapr_pkg::*;

  localparam logic [CMD_W-1:0]     CMD_SPARE      = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE      = 2'd3;
  localparam int                   RANDOM_ITEMS   = 1450;
  localparam int                   PHASE_ITEMS    = 120;
  localparam int                   PRESSURE_PHASE = 3;
  localparam int                   SETTLE_CYCLES  = 6;
  localparam int                   LONG_HOLD      = 400;

  typedef enum int {FLAW_NONE, FLAW_CK_A, FLAW_CK_B, FLAW_CLASS, FLAW_ID} flaw_t;

  logic clk;
  logic rst_n;

  gapr_in_if  in_ch ();
  gapr_out_if out_ch ();
  gapr_cfg_if cfg_ch ();

  int err_count;
  int pending;
  int hold_tokens = 0;
  int sent_items;
  int calm_left;
  bit no_gaps;
  bit in_held;

  // Register values as last written, for building packets
  logic [BYTE_W-1:0]    cur_class;
  logic [BYTE_W-1:0]    cur_id;
  logic [REG_DAT_W-1:0] cur_timeout;

  gnss_ack_packet_receiver i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  gapr_outcome_checker i_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_command    (in_ch.command),
    .in_rx_byte    (in_ch.rx_byte),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_outcome   (out_ch.outcome),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_reg_index (cfg_ch.reg_index),
    .cfg_wdata     (cfg_ch.wdata),
    .err_count     (err_count),
    .pending       (pending)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Outcome receiver: random ready runs and gaps, long hold on request
  initial begin : receiver
    int hold_seen;
    int hold_left;
    int run_left;
    int gap_left;
    hold_seen    = 0;
    hold_left    = 0;
    run_left     = 0;
    gap_left     = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tokens != hold_seen) begin
        hold_seen = hold_tokens;
        hold_left = LONG_HOLD;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        out_ch.ready <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ch.ready <= 1'b0;
      end else begin
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 15);
        gap_left = pick_gap();
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One command transfer, then a random gap
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.rx_byte <= data;
    in_held = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cmd != CMD_SPARE) sent_items++;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 149) == 0) calm_left = 60;
      gap = no_gaps ? 0 : pick_gap();
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every outcome is in and the pipe is empty
  task automatic settle_idle();
    if (in_held) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register transfer
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DAT_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Arm, then the first cut bytes of an acknowledge packet
  task automatic send_packet(input logic [BYTE_W-1:0] msgid, input flaw_t flaw,
                             input bit noisy, input int cut);
    logic [BYTE_W-1:0] pkt [10];
    logic [BYTE_W-1:0] sum_lo;
    logic [BYTE_W-1:0] sum_hi;
    int                i;
    pkt[0] = HDR_SYNC1;
    pkt[1] = HDR_SYNC2;
    pkt[2] = HDR_CLASS;
    pkt[3] = msgid;
    if ($urandom_range(0, 9) == 0) begin
      pkt[4] = 8'($urandom);
      pkt[5] = 8'($urandom);
    end else begin
      pkt[4] = 8'h02;
      pkt[5] = 8'h00;
    end
    pkt[6] = (flaw == FLAW_CLASS) ? cur_class ^ 8'($urandom_range(1, 255)) : cur_class;
    pkt[7] = (flaw == FLAW_ID) ? cur_id ^ 8'($urandom_range(1, 255)) : cur_id;
    sum_lo = '0;
    sum_hi = '0;
    for (i = 2; i < 8; i++) begin
      sum_lo = sum_lo + pkt[i];
      sum_hi = sum_hi + sum_lo;
    end
    pkt[8] = (flaw == FLAW_CK_A) ? sum_lo ^ 8'($urandom_range(1, 255)) : sum_lo;
    pkt[9] = (flaw == FLAW_CK_B) ? sum_hi ^ 8'($urandom_range(1, 255)) : sum_hi;
    send_item(CMD_ARM, 8'($urandom));
    for (i = 0; i < cut; i++) begin
      // noisy packets get stray ticks and off-sequence header bytes
      if (noisy && $urandom_range(0, 7) == 0) send_item(CMD_TICK, 8'($urandom));
      if (noisy && i < 3 && $urandom_range(0, 3) == 0)
        send_item(CMD_BYTE, pkt[i] ^ 8'($urandom_range(1, 255)));
      send_item(CMD_BYTE, pkt[i]);
    end
  endtask

  // Register settings for one random phase, extremes first
  task automatic configure_phase(input int phase);
    logic [BYTE_W-1:0]    cls;
    logic [BYTE_W-1:0]    id;
    logic [REG_DAT_W-1:0] tmo;
    int                   roll;
    case (phase)
      0: begin
        cls = 8'h00;
        id  = 8'hFF;
        tmo = 16'd1;
      end
      1: begin
        cls = 8'hFF;
        id  = 8'h00;
        tmo = 16'hFFFF;
      end
      default: begin
        cls  = 8'($urandom);
        id   = 8'($urandom);
        roll = $urandom_range(0, 9);
        if (roll < 4)      tmo = 16'($urandom_range(1, 30));
        else if (roll < 6) tmo = RST_TIMEOUT;
        else if (roll < 7) tmo = 16'hFFFF;
        else if (roll < 8) tmo = 16'd1;
        else               tmo = 16'($urandom);
      end
    endcase
    // upper data bits of the byte registers are don't-care
    if (phase < 2 || $urandom_range(0, 3) != 0) begin
      write_reg(REG_CLASS, {8'($urandom), cls});
      cur_class = cls;
    end
    if (phase < 2 || $urandom_range(0, 3) != 0) begin
      write_reg(REG_ID, {8'($urandom), id});
      cur_id = id;
    end
    if (phase < 2 || $urandom_range(0, 3) != 0) begin
      write_reg(REG_TIMEOUT, tmo);
      cur_timeout = tmo;
    end
    if (phase == 2 || $urandom_range(0, 4) == 0) write_reg(REG_SPARE, 16'($urandom));
  endtask

  // One random transaction: mostly well-formed packets
  task automatic run_transaction();
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      send_packet(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h01, FLAW_NONE,
                  $urandom_range(0, 2) == 0, 10);
    end else if (roll < 58) begin
      send_packet(NAK_ID, FLAW_NONE, $urandom_range(0, 2) == 0, $urandom_range(4, 10));
    end else if (roll < 72) begin
      send_packet(8'h01, flaw_t'($urandom_range(1, 4)), $urandom_range(0, 1) == 0, 10);
    end else if (roll < 82) begin
      // tick run: runs out when the limit is short
      send_item(CMD_ARM, 8'($urandom));
      if (cur_timeout <= 16'd40) n = int'(cur_timeout) + 1;
      else n = $urandom_range(1, 5);
      repeat (n) send_item(CMD_TICK, 8'($urandom));
    end else if (roll < 90) begin
      send_packet(8'h01, FLAW_NONE, 1'b0, $urandom_range(1, 9));
    end else begin
      repeat ($urandom_range(1, 8)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
    end
  endtask

  // Hold outcomes off while a burst of nak packets fills the block
  task automatic flood_outcomes();
    hold_tokens <= hold_tokens + 1;
    no_gaps = 1'b1;
    repeat (16) begin
      send_item(CMD_ARM, 8'($urandom));
      send_item(CMD_BYTE, HDR_SYNC1);
      send_item(CMD_BYTE, HDR_SYNC2);
      send_item(CMD_BYTE, HDR_CLASS);
      send_item(CMD_BYTE, NAK_ID);
    end
    no_gaps = 1'b0;
    settle_idle();
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int phase;
    int phase_end;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_ARM;
    in_ch.rx_byte    = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_CLASS;
    cfg_ch.wdata     = '0;
    in_held          = 1'b0;
    no_gaps          = 1'b0;
    calm_left        = 0;
    sent_items       = 0;
    cur_class        = RST_CLASS;
    cur_id           = RST_ID;
    cur_timeout      = RST_TIMEOUT;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle input and the spare command are ignored
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_BYTE, HDR_SYNC1);
    send_item(CMD_SPARE, 8'h00);
    // header slip, then nak
    send_item(CMD_ARM, 8'hFF);
    send_item(CMD_SPARE, 8'hFF);
    send_item(CMD_BYTE, HDR_SYNC1);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, HDR_SYNC2);
    send_item(CMD_BYTE, HDR_CLASS);
    send_item(CMD_BYTE, NAK_ID);
    // part of a packet, then re-arm and a matched acknowledge
    send_item(CMD_ARM, 8'h00);
    send_item(CMD_BYTE, HDR_SYNC1);
    send_item(CMD_BYTE, HDR_SYNC2);
    send_packet(8'h01, FLAW_NONE, 1'b0, 10);
    settle_idle();
    // zero limit: first tick times out
    write_reg(REG_TIMEOUT, 16'd0);
    cur_timeout = 16'd0;
    send_item(CMD_ARM, 8'h5A);
    send_item(CMD_TICK, 8'hA5);
    settle_idle();

    // random phases
    sent_items = 0;
    phase      = 0;
    while (sent_items < RANDOM_ITEMS) begin
      settle_idle();
      configure_phase(phase);
      if (phase == PRESSURE_PHASE) flood_outcomes();
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) run_transaction();
      phase++;
    end
    settle_idle();

    if (err_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
